### rtl/pll_pq_divider_search_assert.svh
// Assertion macros for the block's checker.
// Each use stands on a line of its own.
`ifndef PLL_PQ_DIVIDER_SEARCH_ASSERT_SVH
`define PLL_PQ_DIVIDER_SEARCH_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PPD_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pll divider search check failed");

// Consequent checked in the cycle after the antecedent.
`define PPD_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pll divider search check failed");

`endif

### rtl/ppd_pkg.sv
`default_nettype none
package ppd_pkg;

  localparam int RATE_W    = 28;
  localparam int CFG_W     = 30;
  localparam int REF_W     = 27;
  localparam int VLIM_W    = 30;
  localparam int PHMIN_W   = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_NO_SOL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_CLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VCO_MAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VCO_MIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PD_MIN    = 2'd3;

  localparam logic [REF_W-1:0]   RST_REF_CLOCK = 27'd48000000;
  localparam logic [VLIM_W-1:0]  RST_VCO_MAX   = 30'd400000000;
  localparam logic [VLIM_W-1:0]  RST_VCO_MIN   = 30'd100000000;
  localparam logic [PHMIN_W-1:0] RST_PD_MIN    = 24'd250000;

  localparam logic [11:0] P_MIN     = 12'd8;
  localparam logic [11:0] P_MAX     = 12'd2055;
  localparam logic [7:0]  Q_FIRST   = 8'd2;
  localparam logic [7:0]  Q_LAST    = 8'd129;
  localparam logic [6:0]  DIV_FIRST = 7'd127;
  localparam logic [6:0]  DIV_LAST  = 7'd4;
  localparam logic [2:0]  EXT_SH_FIRST = 3'd1;
  localparam logic [2:0]  EXT_SH_LAST  = 3'd4;

  // ppm scale 256e6 = 125000 * 2^11
  localparam int          PPM_K_W   = 17;
  localparam logic [16:0] PPM_K     = 17'd125000;
  localparam int          PPM_SHIFT = 11;
  localparam logic [24:0] MAG_MAX   = 25'h1FFFFFF;

  // quotient bits below the overflow bit, per divider use
  localparam logic [4:0] P_QBITS   = 5'd12;
  localparam logic [4:0] MAG_QBITS = 5'd25;
  localparam logic [4:0] ACH_QBITS = 5'd28;

  localparam logic [1:0] RANGE_LAST_ADC = 2'd1;
  localparam logic [1:0] RANGE_LAST_DAC = 2'd2;

  typedef struct packed {
    logic [26:0] lo_num;
    logic [13:0] lo_den;
    logic [26:0] hi_num;
    logic [13:0] hi_den;
    logic [3:0]  mshift;
  } range_t;

  // edges as num/den in Hz; multiplier as a shift
  function automatic range_t range_lookup(input logic adc, input logic [1:0] idx);
    range_t r;
    r = '0;
    if (adc) begin
      unique case (idx)
        2'd0: r = '{27'd1953125, 14'd10000, 27'd52734375, 14'd1000, 4'd9};
        2'd1: r = '{27'd52734375, 14'd1000, 27'd105468751, 14'd1000, 4'd8};
        default: r = '0;
      endcase
    end else begin
      unique case (idx)
        2'd0: r = '{27'd30000, 14'd1, 27'd54000, 14'd1, 4'd9};
        2'd1: r = '{27'd54000, 14'd1, 27'd108000, 14'd1, 4'd8};
        2'd2: r = '{27'd108000, 14'd1, 27'd2160001, 14'd10, 4'd7};
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  typedef enum logic [4:0] {
    S_IDLE, S_RANGE, S_EXT_INIT, S_DIV_SRCH, S_Q_INIT, S_Q_CHECK, S_P_WAIT,
    S_ACT, S_DIFF, S_PPM_MUL, S_PPM_START, S_PPM_WAIT, S_BEST, S_Q_NEXT,
    S_EXT_NEXT, S_FIN, S_ACH_MUL, S_ACH_START, S_ACH_WAIT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_RANGE, CMD_EXT_INIT, CMD_DIV_STEP, CMD_Q_INIT,
    CMD_P_START, CMD_P_LATCH, CMD_ACT, CMD_DIFF, CMD_PPM_MUL, CMD_PPM_START,
    CMD_PPM_ROUND, CMD_BEST, CMD_Q_NEXT, CMD_EXT_NEXT, CMD_ACH_MUL,
    CMD_ACH_START, CMD_EMIT_OK, CMD_EMIT_OUT, CMD_EMIT_NOSOL
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic range_last;
    logic vco_fit;
    logic div_last;
    logic q_ok;
    logic div_done;
    logic p_ok;
    logic q_last;
    logic es_last;
    logic have;
  } dp_status_t;

endpackage
`default_nettype wire

### rtl/pll_pq_divider_search.sv
// When the rate is outside every range the search ends at the range match;
// otherwise it runs, for each of 4 external dividers, a post divider search
// over up to 124 candidates and then 128 Q steps, a Q step being skipped or
// running its P and ppm divisions; last, the achieved rate is divided out.
// One transaction at a time; the shared radix-2 divider serves every division.
// Synchronous active-high reset restores the default registers; done one cycle.
`default_nettype none
module pll_pq_divider_search
  import ppd_pkg::*;
#(
  parameter int RATE_FRAC_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // command side: a transaction is taken when start is high and busy low
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [RATE_W-1:0]    rate_q8,
  input  wire logic                 converter_select,
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // result, valid for the single cycle that done is high
  output logic                      done,
  output logic [1:0]                status,
  output logic [1:0]                range_index,
  output logic [4:0]                ext_divider,
  output logic [11:0]               p_total,
  output logic [7:0]                q_total,
  output logic [6:0]                post_divider,
  output logic [RATE_W-1:0]         achieved_rate_q8,
  output logic signed [25:0]        ppm_error_q8
);

  cmd_t       cmd;
  dp_status_t st;

  // registers are plain flops, so writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer: range match, per external divider the post divider search,
  // then the Q sweep with P rounding and ppm scoring, then the final rate
  ppd_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .st(st),
    .cmd(cmd),
    .busy(busy)
  );

  // arithmetic, config registers, best-candidate store and the result flops
  ppd_datapath #(
    .RATE_FRAC_BITS(RATE_FRAC_BITS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .st(st),
    .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .rate_q8(rate_q8),
    .converter_select(converter_select),
    .done(done),
    .status(status),
    .range_index(range_index),
    .ext_divider(ext_divider),
    .p_total(p_total),
    .q_total(q_total),
    .post_divider(post_divider),
    .achieved_rate_q8(achieved_rate_q8),
    .ppm_error_q8(ppm_error_q8)
  );

endmodule
`default_nettype wire

### rtl/ppd_divider.sv
`default_nettype none
module ppd_divider
  import ppd_pkg::*;
#(
  parameter int DVD_W = 63,
  parameter int DVS_W = 46,
  parameter int QUO_W = 29
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  input  wire logic [4:0]       nshift,
  output logic                  done,
  output logic [QUO_W-1:0]      quo,
  output logic [DVD_W-1:0]      rem
);

  localparam int CW = (DVS_W + QUO_W > DVD_W) ? DVS_W + QUO_W : DVD_W;

  logic [CW-1:0] dsh;
  logic [4:0]    cnt;
  logic          run;
  logic          ge;

  // restoring division, one quotient bit a cycle, MSB first
  assign ge = CW'(rem) >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == 5'd0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= CW'(divisor) << nshift;
      quo <= '0;
      cnt <= nshift;
    end else if (run) begin
      if (ge) begin
        rem <= rem - dsh[DVD_W-1:0];
      end
      quo <= {quo[QUO_W-2:0], ge};
      dsh <= dsh >> 1;
      cnt <= cnt - 5'd1;
    end
  end

endmodule
`default_nettype wire

### rtl/ppd_datapath.sv
`default_nettype none
module ppd_datapath
  import ppd_pkg::*;
#(
  parameter int RATE_FRAC_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output dp_status_t                st,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic [RATE_W-1:0]    rate_q8,
  input  wire logic                 converter_select,
  output logic                      done,
  output logic [1:0]                status,
  output logic [1:0]                range_index,
  output logic [4:0]                ext_divider,
  output logic [11:0]               p_total,
  output logic [7:0]                q_total,
  output logic [6:0]                post_divider,
  output logic [RATE_W-1:0]         achieved_rate_q8,
  output logic signed [25:0]        ppm_error_q8
);

  localparam int F       = RATE_FRAC_BITS;
  localparam int CLK_W   = RATE_W + 13;
  localparam int VSRCH_W = CLK_W + 7;
  localparam int VOK_W   = VLIM_W + F;
  localparam int NUM_W   = VOK_W + 8;
  localparam int DEN_W   = REF_W + F;
  localparam int PROD_W  = REF_W + 12;
  localparam int ACT_W   = PROD_W + F;
  localparam int X_W     = DEN_W + PPM_K_W;
  localparam int DVD_W   = X_W + PPM_SHIFT;
  localparam int DVS_W   = NUM_W;
  localparam int QUO_W   = 29;
  localparam int ACC_W   = 32;
  localparam int CMP_W   = 43 + F;
  localparam int AD_W    = 15;
  localparam int ADS_W   = AD_W + 13;

  // configuration
  logic [REF_W-1:0]   ref_hz;
  logic [VLIM_W-1:0]  vmax_hz;
  logic [VLIM_W-1:0]  vmin_hz;
  logic [PHMIN_W-1:0] pdmin_hz;

  // working registers
  logic [RATE_W-1:0]  rate_r;
  logic               adc_r;
  logic [1:0]         idx_r;
  logic [3:0]         ms_r;
  logic [2:0]         es_r;
  logic [CLK_W-1:0]   clk_r;
  logic [VSRCH_W-1:0] vco_r;
  logic [6:0]         div_r;
  logic [7:0]         q_r;
  logic [ACC_W-1:0]   acc_r;
  logic [VOK_W-1:0]   vok_r;
  logic [NUM_W-1:0]   num_r;
  logic [11:0]        p_r;
  logic [PROD_W-1:0]  prod_r;
  logic               neg_r;
  logic [DEN_W-1:0]   diff_r;
  logic [X_W-1:0]     x_r;
  logic [24:0]        mag_r;
  logic [AD_W-1:0]    den_r;

  // best candidate
  logic               have_r;
  logic [24:0]        best_mag;
  logic               best_neg;
  logic [2:0]         best_es;
  logic [11:0]        best_p;
  logic [7:0]         best_q;
  logic [6:0]         best_div;

  // divider port
  logic               dv_start;
  logic [DVD_W-1:0]   dv_dividend;
  logic [DVS_W-1:0]   dv_divisor;
  logic [4:0]         dv_nshift;
  logic               dv_done;
  logic [QUO_W-1:0]   dv_quo;
  logic [DVD_W-1:0]   dv_rem;

  range_t             rng;
  logic [CMP_W-1:0]   lhs_lo, lhs_hi, lo_edge, hi_edge;
  logic               last_rng;
  logic               top_ok;
  logic [4:0]         clk_sh;
  logic [CLK_W-1:0]   clk_next;
  logic [VSRCH_W-1:0] clk_ext;
  logic [DEN_W-1:0]   den;
  logic [ACT_W-1:0]   act;
  logic [ACT_W-1:0]   num_ext;
  logic               neg;
  logic [ACT_W-1:0]   diff;
  logic               rnd;
  logic [25:0]        mag_q;
  logic [24:0]        mag;
  logic [ADS_W-1:0]   den2;
  logic [4:0]         ach_sh;

  ppd_divider #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W),
    .QUO_W(QUO_W)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(dv_start),
    .dividend(dv_dividend),
    .divisor(dv_divisor),
    .nshift(dv_nshift),
    .done(dv_done),
    .quo(dv_quo),
    .rem(dv_rem)
  );

  always_comb begin
    rng      = range_lookup(adc_r, idx_r);
    lhs_lo   = CMP_W'(rate_r) * CMP_W'(rng.lo_den);
    lhs_hi   = CMP_W'(rate_r) * CMP_W'(rng.hi_den);
    lo_edge  = CMP_W'(rng.lo_num) << F;
    hi_edge  = CMP_W'(rng.hi_num) << F;
    // last range of a table keeps its top edge
    last_rng = adc_r ? (idx_r == RANGE_LAST_ADC) : (idx_r == RANGE_LAST_DAC);
    top_ok   = last_rng ? (lhs_hi <= hi_edge) : (lhs_hi < hi_edge);

    clk_sh   = 5'(ms_r) + 5'(es_r);
    clk_next = CLK_W'(rate_r) << clk_sh;
    clk_ext  = VSRCH_W'(clk_next);

    den     = DEN_W'(ref_hz) << F;
    act     = ACT_W'(prod_r) << F;
    num_ext = ACT_W'(num_r);
    neg     = act < num_ext;
    diff    = neg ? (num_ext - act) : (act - num_ext);

    rnd   = {dv_rem, 1'b0} >= (DVD_W + 1)'(num_r);
    mag_q = {1'b0, dv_quo[24:0]} + 26'(rnd);
    mag   = (dv_quo[MAG_QBITS] || mag_q[25]) ? MAG_MAX : mag_q[24:0];

    ach_sh = 5'(ms_r) + 5'(best_es);
    den2   = ADS_W'(den_r) << ach_sh;
  end

  always_comb begin
    st.range_last = last_rng;
    st.hit        = (lhs_lo >= lo_edge) && top_ok;
    st.vco_fit    = (vco_r < (VSRCH_W'(vmax_hz) << F)) && (vco_r > (VSRCH_W'(vmin_hz) << F));
    st.div_last   = div_r == DIV_LAST;
    st.q_ok       = (ref_hz != '0) && (ACC_W'(ref_hz) >= acc_r);
    st.div_done   = dv_done;
    st.p_ok       = !dv_quo[P_QBITS] && (dv_quo[11:0] >= P_MIN) && (dv_quo[11:0] <= P_MAX);
    st.q_last     = q_r == Q_LAST;
    st.es_last    = es_r == EXT_SH_LAST;
    st.have       = have_r;
  end

  // divider operand selection
  always_comb begin
    dv_start    = 1'b0;
    dv_dividend = '0;
    dv_divisor  = '0;
    dv_nshift   = '0;
    unique case (cmd)
      CMD_P_START: begin
        dv_start    = 1'b1;
        dv_dividend = (DVD_W'(num_r) << 1) + DVD_W'(den);
        dv_divisor  = DVS_W'(den) << 1;
        dv_nshift   = P_QBITS;
      end
      CMD_PPM_START: begin
        dv_start    = 1'b1;
        dv_dividend = DVD_W'(x_r) << PPM_SHIFT;
        dv_divisor  = num_r;
        dv_nshift   = MAG_QBITS;
      end
      CMD_ACH_START: begin
        dv_start    = 1'b1;
        dv_dividend = (DVD_W'(act) << 1) + DVD_W'(den2);
        dv_divisor  = DVS_W'(den2) << 1;
        dv_nshift   = ACH_QBITS;
      end
      default: begin
        dv_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_hz   <= RST_REF_CLOCK;
      vmax_hz  <= RST_VCO_MAX;
      vmin_hz  <= RST_VCO_MIN;
      pdmin_hz <= RST_PD_MIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REF_CLOCK: ref_hz   <= cfg_data[REF_W-1:0];
        CFG_VCO_MAX:   vmax_hz  <= cfg_data[VLIM_W-1:0];
        CFG_VCO_MIN:   vmin_hz  <= cfg_data[VLIM_W-1:0];
        CFG_PD_MIN:    pdmin_hz <= cfg_data[PHMIN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd == CMD_EMIT_OK) || (cmd == CMD_EMIT_OUT) || (cmd == CMD_EMIT_NOSOL);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        rate_r <= rate_q8;
        adc_r  <= converter_select;
        idx_r  <= '0;
      end
      CMD_RANGE: begin
        if (st.hit) begin
          ms_r   <= rng.mshift;
          es_r   <= EXT_SH_FIRST;
          have_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
      CMD_EXT_INIT: begin
        clk_r <= clk_next;
        vco_r <= (clk_ext << 7) - clk_ext;
        div_r <= DIV_FIRST;
      end
      CMD_DIV_STEP: begin
        vco_r <= vco_r - VSRCH_W'(clk_r);
        div_r <= div_r - 7'd1;
      end
      CMD_Q_INIT: begin
        q_r   <= Q_FIRST;
        acc_r <= ACC_W'(pdmin_hz) << 1;
        vok_r <= vco_r[VOK_W-1:0];
        num_r <= NUM_W'(vco_r[VOK_W-1:0]) << 1;
      end
      CMD_P_LATCH: p_r <= dv_quo[11:0];
      CMD_ACT:     prod_r <= PROD_W'(ref_hz) * PROD_W'(p_r);
      CMD_DIFF: begin
        neg_r  <= neg;
        diff_r <= diff[DEN_W-1:0];
      end
      CMD_PPM_MUL:   x_r <= X_W'(diff_r) * X_W'(PPM_K);
      CMD_PPM_ROUND: mag_r <= mag;
      CMD_BEST: begin
        if (!have_r || mag_r < best_mag) begin
          have_r   <= 1'b1;
          best_mag <= mag_r;
          best_neg <= neg_r && (mag_r != '0);
          best_es  <= es_r;
          best_p   <= p_r;
          best_q   <= q_r;
          best_div <= div_r;
        end
      end
      CMD_Q_NEXT: begin
        q_r   <= q_r + 8'd1;
        acc_r <= acc_r + ACC_W'(pdmin_hz);
        num_r <= num_r + NUM_W'(vok_r);
      end
      CMD_EXT_NEXT: es_r <= es_r + 3'd1;
      CMD_ACH_MUL: begin
        prod_r <= PROD_W'(ref_hz) * PROD_W'(best_p);
        den_r  <= AD_W'(best_q) * AD_W'(best_div);
      end
      CMD_EMIT_OK: begin
        status           <= ST_OK;
        range_index      <= idx_r;
        ext_divider      <= 5'd1 << best_es;
        p_total          <= best_p;
        q_total          <= best_q;
        post_divider     <= best_div;
        achieved_rate_q8 <= dv_quo[ACH_QBITS] ? {RATE_W{1'b1}} : dv_quo[RATE_W-1:0];
        ppm_error_q8     <= best_neg ? -$signed(26'(best_mag)) : $signed(26'(best_mag));
      end
      CMD_EMIT_OUT, CMD_EMIT_NOSOL: begin
        status           <= (cmd == CMD_EMIT_OUT) ? ST_OUTSIDE : ST_NO_SOL;
        range_index      <= (cmd == CMD_EMIT_OUT) ? 2'd0 : idx_r;
        ext_divider      <= '0;
        p_total          <= '0;
        q_total          <= '0;
        post_divider     <= '0;
        achieved_rate_q8 <= '0;
        ppm_error_q8     <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/ppd_ctrl.sv
`default_nettype none
module ppd_ctrl
  import ppd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t st,
  output cmd_t            cmd,
  output logic            busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd        = CMD_LOAD;
          state_next = S_RANGE;
        end
      end
      S_RANGE: begin
        if (st.hit) begin
          cmd        = CMD_RANGE;
          state_next = S_EXT_INIT;
        end else if (st.range_last) begin
          cmd        = CMD_EMIT_OUT;
          state_next = S_IDLE;
        end else begin
          cmd = CMD_RANGE;
        end
      end
      S_EXT_INIT: begin
        cmd        = CMD_EXT_INIT;
        state_next = S_DIV_SRCH;
      end
      S_DIV_SRCH: begin
        if (st.vco_fit) begin
          state_next = S_Q_INIT;
        end else if (st.div_last) begin
          state_next = S_EXT_NEXT;
        end else begin
          cmd = CMD_DIV_STEP;
        end
      end
      S_Q_INIT: begin
        cmd        = CMD_Q_INIT;
        state_next = S_Q_CHECK;
      end
      S_Q_CHECK: begin
        if (st.q_ok) begin
          cmd        = CMD_P_START;
          state_next = S_P_WAIT;
        end else begin
          state_next = S_Q_NEXT;
        end
      end
      S_P_WAIT: begin
        if (st.div_done) begin
          cmd        = CMD_P_LATCH;
          state_next = st.p_ok ? S_ACT : S_Q_NEXT;
        end
      end
      S_ACT: begin
        cmd        = CMD_ACT;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd        = CMD_DIFF;
        state_next = S_PPM_MUL;
      end
      S_PPM_MUL: begin
        cmd        = CMD_PPM_MUL;
        state_next = S_PPM_START;
      end
      S_PPM_START: begin
        cmd        = CMD_PPM_START;
        state_next = S_PPM_WAIT;
      end
      S_PPM_WAIT: begin
        if (st.div_done) begin
          cmd        = CMD_PPM_ROUND;
          state_next = S_BEST;
        end
      end
      S_BEST: begin
        cmd        = CMD_BEST;
        state_next = S_Q_NEXT;
      end
      S_Q_NEXT: begin
        cmd        = CMD_Q_NEXT;
        state_next = st.q_last ? S_EXT_NEXT : S_Q_CHECK;
      end
      S_EXT_NEXT: begin
        cmd        = CMD_EXT_NEXT;
        state_next = st.es_last ? S_FIN : S_EXT_INIT;
      end
      S_FIN: begin
        if (st.have) begin
          state_next = S_ACH_MUL;
        end else begin
          cmd        = CMD_EMIT_NOSOL;
          state_next = S_IDLE;
        end
      end
      S_ACH_MUL: begin
        cmd        = CMD_ACH_MUL;
        state_next = S_ACH_START;
      end
      S_ACH_START: begin
        cmd        = CMD_ACH_START;
        state_next = S_ACH_WAIT;
      end
      S_ACH_WAIT: begin
        if (st.div_done) begin
          cmd        = CMD_EMIT_OK;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/ppd_checker.sv
`default_nettype none
`include "pll_pq_divider_search_assert.svh"
module ppd_checker
  import ppd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire logic [1:0]         status,
  input wire logic [1:0]         range_index,
  input wire logic [4:0]         ext_divider,
  input wire logic [11:0]        p_total,
  input wire logic [7:0]         q_total,
  input wire logic [6:0]         post_divider,
  input wire logic [RATE_W-1:0]  achieved_rate_q8,
  input wire logic signed [25:0] ppm_error_q8
);

  `PPD_ASSERT_NEXT(a_take_busy, clk, rst, start && !busy, busy)
  `PPD_ASSERT_SAME(a_done_after_busy, clk, rst, done, $past(busy))
  `PPD_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `PPD_ASSERT_SAME(a_outside_zero, clk, rst, done && status == ST_OUTSIDE, range_index == 2'd0 && ext_divider == 5'd0 && p_total == 12'd0 && q_total == 8'd0 && post_divider == 7'd0 && achieved_rate_q8 == '0 && ppm_error_q8 == '0)
  `PPD_ASSERT_SAME(a_ok_legal, clk, rst, done && status == ST_OK, p_total >= P_MIN && p_total <= P_MAX && q_total >= Q_FIRST && q_total <= Q_LAST && post_divider >= DIV_LAST && (ext_divider == 5'd2 || ext_divider == 5'd4 || ext_divider == 5'd8 || ext_divider == 5'd16))

endmodule

bind pll_pq_divider_search ppd_checker u_ppd_checker (.*);
`default_nettype wire

### tb/sv/pll_pq_divider_search_tb.sv
`default_nettype none
module pll_pq_divider_search_tb;
  import ppd_pkg::*;

  // one request to the block
  typedef struct {
    logic [RATE_W-1:0] rate;
    logic              adc;
  } rate_req_t;

  // one divider solution as the block should report it
  typedef struct {
    logic [1:0]        status;
    logic [1:0]        range_index;
    logic [4:0]        ext_divider;
    logic [11:0]       p_total;
    logic [7:0]        q_total;
    logic [6:0]        post_divider;
    logic [RATE_W-1:0] achieved;
    logic [25:0]       ppm;
  } pll_solution_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [RATE_W-1:0] rate_q8;
  logic converter_select;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic done;
  logic [1:0] status;
  logic [1:0] range_index;
  logic [4:0] ext_divider;
  logic [11:0] p_total;
  logic [7:0] q_total;
  logic [6:0] post_divider;
  logic [RATE_W-1:0] achieved_rate_q8;
  logic signed [25:0] ppm_error_q8;

  pll_pq_divider_search dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .rate_q8(rate_q8),
    .converter_select(converter_select), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .status(status), .range_index(range_index),
    .ext_divider(ext_divider), .p_total(p_total), .q_total(q_total),
    .post_divider(post_divider), .achieved_rate_q8(achieved_rate_q8),
    .ppm_error_q8(ppm_error_q8)
  );

  // shadow copy of the block's registers
  longint unsigned ref_hz;
  longint unsigned vco_max;
  longint unsigned vco_min;
  longint unsigned pd_min;

  rate_req_t     pending_reqs[$];
  pll_solution_t expected_solutions[$];
  int  errors = 0;
  bit  no_idle;   // long stretch without sender gaps
  bit  hold_tx;   // sender held off until the block drains

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rate range tables, edges in Hz as num/den, multiplier as a factor
  function automatic void range_of(input logic adc, input int idx,
                                   output longint unsigned lo_n, output longint unsigned lo_d,
                                   output longint unsigned hi_n, output longint unsigned hi_d,
                                   output longint unsigned mult);
    lo_n = 0; lo_d = 1; hi_n = 0; hi_d = 1; mult = 0;
    if (adc) begin
      case (idx)
        0: begin lo_n = 1953125;  lo_d = 10000; hi_n = 52734375;  hi_d = 1000; mult = 512; end
        1: begin lo_n = 52734375; lo_d = 1000;  hi_n = 105468751; hi_d = 1000; mult = 256; end
        default: ;
      endcase
    end else begin
      case (idx)
        0: begin lo_n = 30000;  lo_d = 1; hi_n = 54000;   hi_d = 1;  mult = 512; end
        1: begin lo_n = 54000;  lo_d = 1; hi_n = 108000;  hi_d = 1;  mult = 256; end
        2: begin lo_n = 108000; lo_d = 1; hi_n = 2160001; hi_d = 10; mult = 128; end
        default: ;
      endcase
    end
  endfunction

  // full divider search for one requested rate
  function automatic pll_solution_t search_dividers(input logic [RATE_W-1:0] rate_in,
                                                    input logic adc);
    pll_solution_t s;
    longint unsigned rate, lo_n, lo_d, hi_n, hi_d, mult, cnt, found;
    longint unsigned vmax, vmin, ext, clk_w, dv, vco, q, num, den, p, act, diff, mag;
    longint unsigned b_mag, b_ext, b_p, b_q, b_div, numer, ach;
    logic [127:0] wide;
    bit have, neg, b_neg, div_ok, top_ok;
    s = '{default: '0};
    rate = rate_in;
    cnt = adc ? 2 : 3;
    found = cnt;
    for (int i = 0; i < cnt; i++) begin
      range_of(adc, i, lo_n, lo_d, hi_n, hi_d, mult);
      top_ok = (i + 1 == cnt) ? (rate * hi_d <= (hi_n << 8)) : (rate * hi_d < (hi_n << 8));
      if (found == cnt && rate * lo_d >= (lo_n << 8) && top_ok) found = i;
    end
    if (found == cnt) begin
      s.status = ST_OUTSIDE;
      return s;
    end
    s.range_index = found[1:0];
    range_of(adc, int'(found), lo_n, lo_d, hi_n, hi_d, mult);
    vmax = vco_max << 8;
    vmin = vco_min << 8;
    have = 0; b_mag = 0; b_neg = 0; b_ext = 0; b_p = 0; b_q = 0; b_div = 0;
    for (ext = 2; ext <= 16; ext = ext * 2) begin
      clk_w = rate * mult * ext;
      div_ok = 0;
      vco = 0;
      dv = 0;
      for (longint unsigned d = 127; d >= 4; d--) begin
        if (!div_ok && clk_w * d < vmax && clk_w * d > vmin) begin
          div_ok = 1;
          dv = d;
          vco = clk_w * d;
        end
      end
      if (!div_ok) continue;
      for (q = 2; q <= 129; q++) begin
        if (ref_hz == 0 || ref_hz < pd_min * q) continue;
        num = vco * q;
        den = ref_hz << 8;
        p = (2 * num + den) / (2 * den);
        if (p < 8 || p > 2055) continue;
        act = (ref_hz * p) << 8;
        neg = act < num;
        diff = neg ? num - act : act - num;
        // round half up of diff * 256e6 / num
        wide = (128'(diff) * 128'd512000000 + 128'(num)) / (128'(num) * 2);
        mag = (wide > 128'd33554431) ? 33554431 : wide[63:0];
        if (!have || mag < b_mag) begin
          have = 1;
          b_mag = mag;
          b_neg = neg && mag != 0;
          b_ext = ext; b_p = p; b_q = q; b_div = dv;
        end
      end
    end
    if (!have) begin
      s.status = ST_NO_SOL;
      return s;
    end
    numer = (ref_hz * b_p) << 8;
    den = b_q * b_div * b_ext * mult;
    ach = (2 * numer + den) / (2 * den);
    if (ach > 64'hFFFFFFF) ach = 64'hFFFFFFF;
    s.status = ST_OK;
    s.ext_divider = b_ext[4:0];
    s.p_total = b_p[11:0];
    s.q_total = b_q[7:0];
    s.post_divider = b_div[6:0];
    s.achieved = ach[RATE_W-1:0];
    s.ppm = b_neg ? (26'd0 - b_mag[25:0]) : b_mag[25:0];
    return s;
  endfunction

  // driver: start held until the transaction is taken, then the next one or a gap
  always @(posedge clk) begin
    rate_req_t r;
    if (rst) begin
      start <= 1'b0;
      rate_q8 <= '0;
      converter_select <= 1'b0;
    end else begin
      if (start && !busy)
        expected_solutions.push_back(search_dividers(rate_q8, converter_select));
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && !hold_tx &&
            (no_idle || $urandom_range(99) >= 19)) begin
          r = pending_reqs.pop_front();
          start <= 1'b1;
          rate_q8 <= r.rate;
          converter_select <= r.adc;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: each done strobe against the oldest expectation
  always @(posedge clk) begin
    pll_solution_t e;
    if (!rst && done) begin
      if (expected_solutions.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, status);
        errors++;
      end else begin
        e = expected_solutions.pop_front();
        if (status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, status);
          errors++;
        end
        if (range_index !== e.range_index) begin
          $display("%0t: range_index exp %0d got %0d", $time, e.range_index, range_index);
          errors++;
        end
        if (ext_divider !== e.ext_divider) begin
          $display("%0t: ext_divider exp %0d got %0d", $time, e.ext_divider, ext_divider);
          errors++;
        end
        if (p_total !== e.p_total) begin
          $display("%0t: p_total exp %0d got %0d", $time, e.p_total, p_total);
          errors++;
        end
        if (q_total !== e.q_total) begin
          $display("%0t: q_total exp %0d got %0d", $time, e.q_total, q_total);
          errors++;
        end
        if (post_divider !== e.post_divider) begin
          $display("%0t: post_divider exp %0d got %0d", $time, e.post_divider, post_divider);
          errors++;
        end
        if (achieved_rate_q8 !== e.achieved) begin
          $display("%0t: achieved_rate_q8 exp %0d got %0d", $time, e.achieved,
                   achieved_rate_q8);
          errors++;
        end
        if (ppm_error_q8 !== e.ppm) begin
          $display("%0t: ppm_error_q8 exp %0d got %0d", $time, $signed(e.ppm),
                   ppm_error_q8);
          errors++;
        end
      end
    end
  end

  // register write through the config channel; shadow copy follows on the handshake
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_REF_CLOCK: ref_hz = val & 30'h7FFFFFF;
      CFG_VCO_MAX:   vco_max = val;
      CFG_VCO_MIN:   vco_min = val;
      CFG_PD_MIN:    pd_min = val & 30'hFFFFFF;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // block back to idle: every transaction sent and answered
  // (sampled mid-cycle so the driver's updates have settled)
  task automatic drain();
    @(negedge clk);
    while (pending_reqs.size() != 0 || start || expected_solutions.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_req(input logic [RATE_W-1:0] r, input logic a);
    rate_req_t x;
    x.rate = r;
    x.adc = a;
    pending_reqs.push_back(x);
  endtask

  // mostly rates inside a range, uniformly spread; the rest anywhere
  task automatic add_random(input int n);
    logic a;
    int idx;
    longint unsigned lo, hi;
    for (int i = 0; i < n; i++) begin
      a = 1'($urandom_range(1));
      if ($urandom_range(99) < 15) begin
        add_req(RATE_W'($urandom), a);
      end else begin
        idx = a ? $urandom_range(1) : $urandom_range(2);
        case ({a, idx[1:0]})
          3'b100:  begin lo = 50000;    hi = 13499999; end
          3'b101:  begin lo = 13500000; hi = 27000000; end
          3'b000:  begin lo = 7680000;  hi = 13823999; end
          3'b001:  begin lo = 13824000; hi = 27647999; end
          default: begin lo = 27648000; hi = 55296025; end
        endcase
        add_req(RATE_W'(lo + ($urandom % (hi - lo + 1))), a);
      end
    end
  endtask

  initial begin
    no_idle = 1'b0;
    hold_tx = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_REF_CLOCK;
    cfg_data = '0;
    ref_hz = 48000000;
    vco_max = 400000000;
    vco_min = 100000000;
    pd_min = 250000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: range edges both sides, zero and full scale, both tables
    add_req(0, 1'b1);
    add_req(28'hFFFFFFF, 1'b1);
    add_req(0, 1'b0);
    add_req(28'hFFFFFFF, 1'b0);
    add_req(49999, 1'b1);
    add_req(50000, 1'b1);
    add_req(13499999, 1'b1);
    add_req(13500000, 1'b1);
    add_req(27000000, 1'b1);     // top edge of last ADC range, included
    add_req(27000001, 1'b1);
    add_req(7679999, 1'b0);
    add_req(7680000, 1'b0);
    add_req(13823999, 1'b0);
    add_req(13824000, 1'b0);
    add_req(27647999, 1'b0);
    add_req(27648000, 1'b0);
    add_req(55296025, 1'b0);     // top edge of last DAC range, included
    add_req(55296026, 1'b0);
    add_req(12288000, 1'b1);     // 48 kHz
    add_req(11289600, 1'b0);     // 44.1 kHz
    add_req(28'h5555555, 1'b1);
    add_req(28'hAAAAAAA, 1'b0);
    drain();

    // defaults, first half without sender gaps
    no_idle = 1'b1;
    add_random(20);
    drain();
    no_idle = 1'b0;
    add_random(10);
    // hold the sender mid-stream until the block has answered everything
    while (pending_reqs.size() != 0) @(posedge clk);
    hold_tx = 1'b1;
    @(negedge clk);
    while (start || expected_solutions.size() != 0) @(negedge clk);
    hold_tx = 1'b0;
    add_random(10);
    drain();

    // widest limits: fastest reference, widest VCO window, lowest detector limit
    write_reg(CFG_REF_CLOCK, 30'd100000000);
    write_reg(CFG_VCO_MAX, 30'd1000000000);
    write_reg(CFG_VCO_MIN, 30'd1000000);
    write_reg(CFG_PD_MIN, 30'd1000);
    add_random(20);
    drain();

    // slowest reference with highest detector limit: no Q passes
    write_reg(CFG_REF_CLOCK, 30'd1000000);
    write_reg(CFG_PD_MIN, 30'd10000000 | 30'h3000000);  // high bits masked off
    add_random(8);
    drain();

    // zero reference after masking, and an empty VCO window
    write_reg(CFG_REF_CLOCK, 30'h8000000);
    write_reg(CFG_VCO_MAX, 30'd1000000000);
    write_reg(CFG_VCO_MIN, 30'd1000000000);
    write_reg(CFG_PD_MIN, 30'd250000);
    add_random(5);
    drain();

    // ordinary mid-range settings
    write_reg(CFG_REF_CLOCK, 30'd27000000 | 30'h38000000);
    write_reg(CFG_VCO_MAX, 30'd500000000);
    write_reg(CFG_VCO_MIN, 30'd50000000);
    write_reg(CFG_PD_MIN, 30'd100000);
    add_random(22);
    drain();

    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("pll_pq_divider_search_tb OK");
    else
      $display("pll_pq_divider_search_tb NOT OK");
    $finish;
  end

  initial begin
    #400000000;
    $display("pll_pq_divider_search_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
